>>> rtl/vpa_pkg.sv
package vpa_pkg;

   localparam int NumParts  = 16;
   localparam int TotalSize = 1024;
   localparam int IdxW      = 4;
   localparam int CntW      = 5;
   localparam int AddrW     = 10;
   localparam int SizeW     = 11;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_BAD_SIZE     = 3'd1,
      STATUS_NO_SPACE     = 3'd2,
      STATUS_BAD_INDEX    = 3'd3,
      STATUS_ALREADY_FREE = 3'd4,
      STATUS_TABLE_FULL   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FIT_FIRST  = 2'd0,
      FIT_BEST   = 2'd1,
      FIT_WORST  = 2'd2,
      FIT_UNUSED = 2'd3
   } fit_type;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] CSR_FIT_POLICY = 2'd0;

   typedef struct packed {
      logic load;
      logic scan;
      logic decide;
      logic merge;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/vpa_req_if.sv
interface vpa_req_if;
   logic        valid;
   logic        ready;
   logic [0:0]  operation;
   logic [10:0] request_size;
   logic [3:0]  part_index;

   modport source (output valid, operation, request_size, part_index, input ready);
   modport sink   (input valid, operation, request_size, part_index, output ready);
endinterface

>>> rtl/vpa_rsp_if.sv
interface vpa_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [9:0] start_address;
   logic [3:0] result_index;
   logic [4:0] part_count;

   modport source (output valid, status, start_address, result_index, part_count,
                   input ready);
   modport sink   (input valid, status, start_address, result_index, part_count,
                   output ready);
endinterface

>>> rtl/variable_partition_allocator_unit.sv
// Partition allocator over a 1024-unit region with a 16-entry address-ordered
// table. An allocate scans the table with the single shared compare unit,
// which visits one table entry per cycle (first fit stops at the first hit,
// best and worst fit walk every used entry); a free ends its scan at once.
// One transaction is in work at a time; the result register lets the next
// request enter while a result waits.
module variable_partition_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   vpa_req_if.sink     req_chan,
   vpa_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vpa_pkg::*;

   logic [1:0] fit_policy_ff, fit_policy_in;
   cmd_type    cmd;
   stat_type   stat;

   assign csr_pready = 1'b1;
   assign csr_prdata = {30'd0, fit_policy_ff};

   always_comb begin
      fit_policy_in = fit_policy_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_FIT_POLICY))
         fit_policy_in = csr_pwdata[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) fit_policy_ff <= FIT_FIRST;
      else       fit_policy_ff <= fit_policy_in;
   end

   vpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vpa_table u_table (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .fit_policy    (fit_policy_ff),
      .req_operation (req_chan.operation[0]),
      .req_size      (req_chan.request_size),
      .req_index     (req_chan.part_index),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_status    (rsp_chan.status),
      .rsp_address   (rsp_chan.start_address),
      .rsp_index     (rsp_chan.result_index),
      .rsp_count     (rsp_chan.part_count)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.part_count != 5'd0) && (rsp_chan.part_count <= 5'd16))
      else $error("partition count out of range");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while another is in work");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status != STATUS_OK)) |->
         (rsp_chan.start_address == '0) && (rsp_chan.result_index == '0))
      else $error("failed request reports a partition");

endmodule

>>> rtl/vpa_ctrl.sv
module vpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vpa_pkg::stat_type stat,
   output vpa_pkg::cmd_type  cmd
);
   import vpa_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_DECIDE = 5'b00100,
      S_MERGE  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_MERGE;
         end
         S_MERGE: begin
            cmd.merge = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/vpa_table.sv
module vpa_table (
   input  logic                       clock,
   input  logic                       reset,
   input  vpa_pkg::cmd_type           cmd,
   output vpa_pkg::stat_type          stat,
   input  logic [1:0]                 fit_policy,
   input  logic                       req_operation,
   input  logic [vpa_pkg::SizeW-1:0]  req_size,
   input  logic [vpa_pkg::IdxW-1:0]   req_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_status,
   output logic [vpa_pkg::AddrW-1:0]  rsp_address,
   output logic [vpa_pkg::IdxW-1:0]   rsp_index,
   output logic [vpa_pkg::CntW-1:0]   rsp_count
);
   import vpa_pkg::*;

   logic [AddrW-1:0] start_ff [NumParts];
   logic [AddrW-1:0] start_in [NumParts];
   logic [SizeW-1:0] size_ff  [NumParts];
   logic [SizeW-1:0] size_in  [NumParts];
   logic [NumParts-1:0] busy_ff, busy_in;
   logic [CntW-1:0]  used_ff, used_in;

   logic             op_ff, op_in;
   logic [SizeW-1:0] rsize_ff, rsize_in;
   logic [IdxW-1:0]  ridx_ff, ridx_in;
   logic [IdxW-1:0]  ptr_ff, ptr_in;
   logic             found_ff, found_in;
   logic [IdxW-1:0]  pick_ff, pick_in;
   logic [SizeW-1:0] picksz_ff, picksz_in;
   status_type       res_status_ff, res_status_in;
   logic [IdxW-1:0]  res_idx_ff, res_idx_in;
   logic             ok_ff, ok_in;

   logic             out_valid_ff, out_valid_in;
   status_type       out_status_ff, out_status_in;
   logic [AddrW-1:0] out_addr_ff, out_addr_in;
   logic [IdxW-1:0]  out_idx_ff, out_idx_in;
   logic [CntW-1:0]  out_count_ff, out_count_in;

   logic             cand, better, stop_at_hit;
   logic [CntW-1:0]  ptr_next, pick_next, ridx_next, res_ok_idx;
   logic [IdxW-1:0]  nxt_idx, prv_idx;

   assign stop_at_hit = (fit_policy != FIT_BEST) && (fit_policy != FIT_WORST);
   assign ptr_next  = {1'b0, ptr_ff} + CntW'(1);
   assign pick_next = {1'b0, pick_ff} + CntW'(1);
   assign ridx_next = {1'b0, ridx_ff} + CntW'(1);
   assign nxt_idx   = ridx_ff + IdxW'(1);
   assign prv_idx   = res_idx_ff - IdxW'(1);
   assign res_ok_idx = {1'b0, res_idx_ff};

   assign cand = ({1'b0, ptr_ff} < used_ff) && !busy_ff[ptr_ff] && (size_ff[ptr_ff] >= rsize_ff);
   assign better = !found_ff
                || ((fit_policy == FIT_BEST)  && (size_ff[ptr_ff] < picksz_ff))
                || ((fit_policy == FIT_WORST) && (size_ff[ptr_ff] > picksz_ff));

   assign stat.scan_done = (op_ff == OP_FREE) || (ptr_ff == IdxW'(NumParts - 1))
                        || (ptr_next >= used_ff) || (cand && stop_at_hit);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      start_in      = start_ff;
      size_in       = size_ff;
      busy_in       = busy_ff;
      used_in       = used_ff;
      op_in         = op_ff;
      rsize_in      = rsize_ff;
      ridx_in       = ridx_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      picksz_in     = picksz_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      ok_in         = ok_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_addr_in   = out_addr_ff;
      out_idx_in    = out_idx_ff;
      out_count_in  = out_count_ff;

      if (cmd.load) begin
         op_in    = req_operation;
         rsize_in = req_size;
         ridx_in  = req_index;
         ptr_in   = '0;
         found_in = 1'b0;
         ok_in    = 1'b0;
      end

      if (cmd.scan) begin
         ptr_in = ptr_ff + IdxW'(1);
         if (cand && better) begin
            found_in  = 1'b1;
            pick_in   = ptr_ff;
            picksz_in = size_ff[ptr_ff];
         end
      end

      if (cmd.decide) begin
         res_idx_in = '0;
         if (op_ff == OP_ALLOC) begin
            if (rsize_ff == '0) begin
               res_status_in = STATUS_BAD_SIZE;
            end else if (!found_ff) begin
               res_status_in = STATUS_NO_SPACE;
            end else if (picksz_ff == rsize_ff) begin
               busy_in[pick_ff] = 1'b1;
               res_status_in    = STATUS_OK;
               res_idx_in       = pick_ff;
            end else if (used_ff == CntW'(NumParts)) begin
               res_status_in = STATUS_TABLE_FULL;
            end else begin
               // split: front becomes busy, shift the tail up by one
               for (int k = 1; k < NumParts; k++) begin
                  if (CntW'(k) > pick_next) begin
                     start_in[k] = start_ff[k-1];
                     size_in[k]  = size_ff[k-1];
                     busy_in[k]  = busy_ff[k-1];
                  end else if (CntW'(k) == pick_next) begin
                     start_in[k] = start_ff[pick_ff] + AddrW'(rsize_ff);
                     size_in[k]  = size_ff[pick_ff] - rsize_ff;
                     busy_in[k]  = 1'b0;
                  end
               end
               size_in[pick_ff] = rsize_ff;
               busy_in[pick_ff] = 1'b1;
               used_in          = used_ff + CntW'(1);
               res_status_in    = STATUS_OK;
               res_idx_in       = pick_ff;
            end
         end else begin
            if ({1'b0, ridx_ff} >= used_ff) begin
               res_status_in = STATUS_BAD_INDEX;
            end else if (!busy_ff[ridx_ff]) begin
               res_status_in = STATUS_ALREADY_FREE;
            end else begin
               busy_in[ridx_ff] = 1'b0;
               res_status_in    = STATUS_OK;
               res_idx_in       = ridx_ff;
               ok_in            = 1'b1;
               if ((ridx_next < used_ff) && !busy_ff[nxt_idx]) begin
                  size_in[ridx_ff] = size_ff[ridx_ff] + size_ff[nxt_idx];
                  for (int k = 0; k < NumParts - 1; k++) begin
                     if (CntW'(k) >= ridx_next) begin
                        start_in[k] = start_ff[k+1];
                        size_in[k]  = size_ff[k+1];
                        busy_in[k]  = busy_ff[k+1];
                     end
                  end
                  used_in = used_ff - CntW'(1);
               end
            end
         end
      end

      if (cmd.merge && ok_ff && (res_idx_ff != '0) && !busy_ff[prv_idx]) begin
         size_in[prv_idx] = size_ff[prv_idx] + size_ff[res_idx_ff];
         for (int k = 0; k < NumParts - 1; k++) begin
            if (CntW'(k) >= res_ok_idx) begin
               start_in[k] = start_ff[k+1];
               size_in[k]  = size_ff[k+1];
               busy_in[k]  = busy_ff[k+1];
            end
         end
         used_in    = used_ff - CntW'(1);
         res_idx_in = prv_idx;
      end

      if (cmd.publish) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_count_in  = used_ff;
         if (res_status_ff == STATUS_OK) begin
            out_addr_in = start_ff[res_idx_ff];
            out_idx_in  = res_idx_ff;
         end else begin
            out_addr_in = '0;
            out_idx_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumParts; k++) begin
            start_ff[k] <= '0;
            size_ff[k]  <= '0;
         end
         size_ff[0]   <= SizeW'(TotalSize);
         busy_ff      <= '0;
         used_ff      <= CntW'(1);
         out_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         size_ff      <= size_in;
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
      end
      op_ff         <= op_in;
      rsize_ff      <= rsize_in;
      ridx_ff       <= ridx_in;
      ptr_ff        <= ptr_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      picksz_ff     <= picksz_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      ok_ff         <= ok_in;
      out_status_ff <= out_status_in;
      out_addr_ff   <= out_addr_in;
      out_idx_ff    <= out_idx_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_index   = out_idx_ff;
   assign rsp_count   = out_count_ff;

endmodule
